FILE: src/pfa_pkg.sv
// ---------------------------------------------------------------------------
// pfa_pkg: shared types and codes for the page frame allocator
// Field widths, operation and status codes, register indexes, queue types.
// ---------------------------------------------------------------------------
package pfa_pkg;

    localparam int PAGE_W      = 15;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int FREE_W      = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 15;

    localparam int NUM_PAGES_DEF   = 32768;
    localparam int COUNT_WIDTH_DEF = 8;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_INC   = 2'd2;
    localparam logic [FUNC_W-1:0] FN_DEC   = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_PAGE   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ZERO_COUNT = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_STACK_FULL = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_SHARED     = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_SATURATED  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_PAGE  = 4'd1;

    localparam logic [PAGE_W-1:0] PAGE_MAX = 15'h7FFF;

    // classified request
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PAGE_W-1:0] page;
        logic              bad;
    } op_t;

    typedef struct packed {
        logic push;
        op_t  op;
    } q_push_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } q_head_t;

endpackage

FILE: src/pfa_req_if.sv
// ---------------------------------------------------------------------------
// pfa_req_if: request channel
// Valid/ready channel carrying one allocator request.
// ---------------------------------------------------------------------------
interface pfa_req_if import pfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output func, output page_number, input ready);
    modport sink   (input valid, input func, input page_number, output ready);
endinterface

FILE: src/pfa_rsp_if.sv
// ---------------------------------------------------------------------------
// pfa_rsp_if: response channel
// Valid/ready channel carrying one allocator response.
// ---------------------------------------------------------------------------
interface pfa_rsp_if import pfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PAGE_W-1:0]   granted_page;
    logic [STATUS_W-1:0] status;
    logic [FREE_W-1:0]   pages_free;

    modport source (output valid, output granted_page, output status,
                    output pages_free, input ready);
    modport sink   (input valid, input granted_page, input status,
                    input pages_free, output ready);
endinterface

FILE: src/pfa_cfg_if.sv
// ---------------------------------------------------------------------------
// pfa_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface pfa_cfg_if import pfa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/refcounted_page_frame_allocator_core.sv
// ---------------------------------------------------------------------------
// refcounted_page_frame_allocator_core: page frame allocator top level
// LIFO free-page stack with a per-page reference count.
// ---------------------------------------------------------------------------
// Requests (alloc, free, increment, decrement) enter on req and each yields
// exactly one response on rsp, in order. The intake side checks page numbers
// against NUM_PAGES, and freed pages also against first_page/last_page, and
// parks requests in a two-entry queue; the execution side takes one request
// at a time in two steps: a start step that reads the count memory and the
// top of the free stack, and an execute step that writes them as needed and
// loads the response register. A response may wait for rsp.ready while the
// next request is taken in. After reset the count memory is swept to zero,
// one entry per cycle; req.ready stays low until the sweep is done, while
// configuration writes are taken at all times. To start up, free every page
// to be managed. Configuration must only be written while no request is in
// flight.
// ---------------------------------------------------------------------------
module refcounted_page_frame_allocator_core import pfa_pkg::*; #(
    parameter int NUM_PAGES   = NUM_PAGES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pfa_cfg_if.sink   cfg,
    pfa_req_if.sink   req,
    pfa_rsp_if.source rsp
);

    q_push_t q_push;
    q_head_t q_head;
    logic    q_full;
    logic    q_pop;
    logic    busy;

    // intake: range registers and request classification
    pfa_front #(
        .NUM_PAGES (NUM_PAGES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .req    (req),
        .q_full (q_full),
        .busy   (busy),
        .push   (q_push)
    );

    // decouples intake from execution
    pfa_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop),
        .full  (q_full),
        .head  (q_head)
    );

    // execution: stack, counts, response
    pfa_back #(
        .NUM_PAGES   (NUM_PAGES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (q_head),
        .pop   (q_pop),
        .busy  (busy),
        .rsp   (rsp)
    );

endmodule

FILE: src/pfa_front.sv
// ---------------------------------------------------------------------------
// pfa_front: request intake
// Holds the range registers, accepts requests and flags bad page numbers.
// ---------------------------------------------------------------------------
module pfa_front import pfa_pkg::*; #(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    pfa_cfg_if.sink  cfg,
    pfa_req_if.sink  req,
    input  logic     q_full,
    input  logic     busy,
    output q_push_t  push
);

    logic [PAGE_W-1:0] first_page_reg;
    logic [PAGE_W-1:0] last_page_reg;
    logic              in_table;
    logic              out_of_range;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_page_reg <= '0;
            last_page_reg  <= PAGE_MAX;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FIRST_PAGE: first_page_reg <= cfg.data;
                REG_LAST_PAGE:  last_page_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    assign req.ready = !q_full && !busy;

    assign in_table     = 32'(req.page_number) < 32'(NUM_PAGES);
    assign out_of_range = (req.page_number < first_page_reg) ||
                          (req.page_number > last_page_reg);

    always_comb
    begin
        push.push    = req.valid && req.ready;
        push.op.func = req.func;
        push.op.page = req.page_number;
        unique case (req.func)
            FN_ALLOC: push.op.bad = 1'b0;
            FN_FREE:  push.op.bad = !in_table || out_of_range;
            default:  push.op.bad = !in_table;
        endcase
    end

endmodule

FILE: src/pfa_queue.sv
// ---------------------------------------------------------------------------
// pfa_queue: request queue
// Two-entry FIFO between intake and execution.
// ---------------------------------------------------------------------------
module pfa_queue import pfa_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  q_push_t push,
    input  logic    pop,
    output logic    full,
    output q_head_t head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    op_t              slot_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = cnt_reg == (PTR_W+1)'(DEPTH);
    assign head.valid = cnt_reg != '0;
    assign head.op    = slot_reg[rd_ptr_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + (PTR_W+1)'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.op;
    end

endmodule

FILE: src/pfa_back.sv
// ---------------------------------------------------------------------------
// pfa_back: execution engine
// Free stack, reference count memory, clearing pass and response register.
// ---------------------------------------------------------------------------
module pfa_back import pfa_pkg::*; #(
    parameter int NUM_PAGES   = NUM_PAGES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  q_head_t   head,
    output logic      pop,
    output logic      busy,
    pfa_rsp_if.source rsp
);

    localparam int PIDX_W  = $clog2(NUM_PAGES);
    localparam int DEPTH_W = $clog2(NUM_PAGES + 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    function automatic logic [PIDX_W-1:0] page_idx(input logic [PAGE_W-1:0] p);
        logic [31:0] w;
        w = 32'(p);
        return w[PIDX_W-1:0];
    endfunction

    logic [PAGE_W-1:0]      stack_mem [0:NUM_PAGES-1];
    logic [COUNT_WIDTH-1:0] count_mem [0:NUM_PAGES-1];

    logic [1:0]             state_reg, state_next;
    logic [PIDX_W-1:0]      clr_idx_reg;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    op_t                    op_reg;
    logic [COUNT_WIDTH-1:0] cnt_rd_reg;
    logic [PAGE_W-1:0]      stk_rd_reg;

    logic                   out_valid_reg;
    logic [PAGE_W-1:0]      granted_reg, granted_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [FREE_W-1:0]      free_reg;

    logic                   start;
    logic [DEPTH_W-1:0]     depth_m1;
    logic                   cnt_we;
    logic [PIDX_W-1:0]      cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic                   stk_we;
    logic                   cnt_zero, cnt_shared, cnt_max;
    logic                   stack_full;
    logic [31:0]            depth_ext;

    assign busy     = state_reg == S_CLEAR;
    assign start    = (state_reg == S_IDLE) && head.valid && (!out_valid_reg || rsp.ready);
    assign pop      = start;
    assign depth_m1 = depth_reg - DEPTH_W'(1);

    assign cnt_zero   = cnt_rd_reg == '0;
    assign cnt_shared = cnt_rd_reg > COUNT_WIDTH'(1);
    assign cnt_max    = &cnt_rd_reg;
    assign stack_full = depth_reg >= DEPTH_W'(NUM_PAGES);

    always_comb
    begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        cnt_we       = 1'b0;
        cnt_waddr    = page_idx(op_reg.page);
        cnt_wdata    = cnt_rd_reg;
        stk_we       = 1'b0;
        granted_next = '0;
        status_next  = STAT_OK;
        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_idx_reg;
                cnt_wdata = '0;
                if (clr_idx_reg == PIDX_W'(NUM_PAGES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                case (op_reg.func)
                    FN_ALLOC:
                    begin
                        if (depth_reg == '0)
                            status_next = STAT_EMPTY;
                        else
                        begin
                            depth_next   = depth_m1;
                            granted_next = stk_rd_reg;
                            if (32'(stk_rd_reg) < 32'(NUM_PAGES))
                            begin
                                cnt_we    = 1'b1;
                                cnt_waddr = page_idx(stk_rd_reg);
                                cnt_wdata = COUNT_WIDTH'(1);
                            end
                        end
                    end
                    FN_FREE:
                    begin
                        if (op_reg.bad)
                            status_next = STAT_BAD_PAGE;
                        else if (cnt_shared)
                        begin
                            cnt_we      = 1'b1;
                            cnt_wdata   = cnt_rd_reg - COUNT_WIDTH'(1);
                            status_next = STAT_SHARED;
                        end
                        else if (stack_full)
                            status_next = STAT_STACK_FULL;
                        else
                        begin
                            stk_we     = 1'b1;
                            depth_next = depth_reg + DEPTH_W'(1);
                        end
                    end
                    FN_INC:
                    begin
                        if (op_reg.bad)
                            status_next = STAT_BAD_PAGE;
                        else if (cnt_zero)
                            status_next = STAT_ZERO_COUNT;
                        else if (cnt_max)
                            status_next = STAT_SATURATED;
                        else
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = cnt_rd_reg + COUNT_WIDTH'(1);
                        end
                    end
                    default:
                    begin
                        if (op_reg.bad)
                            status_next = STAT_BAD_PAGE;
                        else if (cnt_zero)
                            status_next = STAT_ZERO_COUNT;
                        else
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = cnt_rd_reg - COUNT_WIDTH'(1);
                        end
                    end
                endcase
            end
            default: state_next = S_CLEAR;
        endcase
    end

    assign depth_ext = 32'(depth_next);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            if (state_reg == S_CLEAR)
                clr_idx_reg <= clr_idx_reg + PIDX_W'(1);
            if (state_reg == S_EXEC)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (start)
            op_reg <= head.op;
        if (state_reg == S_EXEC)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
            free_reg    <= depth_ext[FREE_W-1:0];
        end
    end

    // memories: registered reads at request start, writes in the clearing pass and the execute cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_rd_reg <= count_mem[page_idx(head.op.page)];
            stk_rd_reg <= stack_mem[depth_m1[PIDX_W-1:0]];
        end
        if (cnt_we)
            count_mem[cnt_waddr] <= cnt_wdata;
        if (stk_we)
            stack_mem[depth_reg[PIDX_W-1:0]] <= op_reg.page;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted_page = granted_reg;
    assign rsp.status       = status_reg;
    assign rsp.pages_free   = free_reg;

    a_exec_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> $past(state_reg) == S_IDLE)
        else $error("execute cycle not preceded by start");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= 32'(NUM_PAGES))
        else $error("free stack depth beyond page count");

    a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> !out_valid_reg)
        else $error("response register occupied in execute cycle");

    a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !out_valid_reg && !pop)
        else $error("activity during clearing pass");

endmodule
